// ----- hdl/tcwu_pkg.sv -----
// Shared widths, constants, register codes and control bundles for the
// congestion window update block. No dependencies.
package tcwu_pkg;

   localparam int WIN_W     = 19;
   localparam int STEP_W    = 10;
   localparam int FACTOR_W  = 8;
   localparam int PROB_W    = 17;
   localparam int DRAW_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int FRAC_W    = 8;
   localparam int PROD_W    = FACTOR_W + WIN_W;
   localparam int QUO_W     = STEP_W + FRAC_W;
   localparam int SUM_W     = WIN_W + 1;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [WIN_W-1:0] WIN_ONE = 19'd256;
   localparam logic [WIN_W-1:0] WIN_MAX = 19'd262144;
   localparam logic [WIN_W-1:0] WIN_INF = '1;
   localparam logic [PROB_W:0]  PROB_ONE = 18'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WINDOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_START_STEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVOID_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOSS_FACTOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUCCESS_PROB    = 3'd4;

   localparam logic [STEP_W-1:0]   RST_SLOW_START_STEP = 10'd256;
   localparam logic [STEP_W-1:0]   RST_AVOID_GAIN      = 10'd256;
   localparam logic [FACTOR_W-1:0] RST_LOSS_FACTOR     = 8'd128;
   localparam logic [PROB_W-1:0]   RST_SUCCESS_PROB    = 17'd65536;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_start;
      logic div_step;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic lost;
      logic slow;
   } status_type;

   function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = {{(WIN_W-1){1'b0}}, 1'b1};
      end else if (w > WIN_MAX) begin
         r = WIN_MAX;
      end
      return r;
   endfunction

endpackage

// ----- hdl/tcwu_ctrl.sv -----
// Sequencer for the congestion window update: handshakes and datapath commands.
// Depends on tcwu_pkg.
module tcwu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcwu_pkg::status_type status,
   output tcwu_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_DIV,
      S_FINISH,
      S_PUSH
   } state_type;

   state_type                    state_ff, state_in;
   logic [tcwu_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.lost || status.slow) begin
               cmd.update = 1'b1;
               state_in   = S_PUSH;
            end else begin
               cmd.div_start = 1'b1;
               cnt_in        = tcwu_pkg::CNT_W'(tcwu_pkg::DIV_STEPS - 1);
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FINISH: begin
            cmd.update = 1'b1;
            state_in   = S_PUSH;
         end
         S_PUSH: begin
            if (out_free) begin
               cmd.push     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/tcwu_dpath.sv -----
// Datapath: configuration registers, window state, decrease multiplier,
// bit-serial avoidance divider and result register. Depends on tcwu_pkg.
module tcwu_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [tcwu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tcwu_pkg::WIN_W-1:0]        csr_wdata,
   input  logic [tcwu_pkg::DRAW_W-1:0]       req_random_draw,
   input  tcwu_pkg::cmd_type                 cmd,
   output tcwu_pkg::status_type              status,
   output logic [tcwu_pkg::WIN_W-1:0]        rsp_window,
   output logic                              rsp_in_slow_start,
   output logic                              rsp_loss_seen
);

   logic [tcwu_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [tcwu_pkg::STEP_W-1:0]   gain_ff, gain_in;
   logic [tcwu_pkg::FACTOR_W-1:0] factor_ff, factor_in;
   logic [tcwu_pkg::PROB_W-1:0]   prob_ff, prob_in;

   logic [tcwu_pkg::WIN_W-1:0]    win_ff, win_in;
   logic [tcwu_pkg::WIN_W-1:0]    thr_ff, thr_in;
   logic                          slow_ff, slow_in;

   logic                          lost_ff;
   logic [tcwu_pkg::PROD_W-1:0]   prod_ff;
   logic [tcwu_pkg::WIN_W-1:0]    rem_ff;
   logic [tcwu_pkg::QUO_W-1:0]    quo_ff;
   logic [tcwu_pkg::WIN_W-1:0]    out_win_ff;
   logic                          out_slow_ff;
   logic                          out_lost_ff;

   logic [tcwu_pkg::PROB_W:0]     ack_sum;
   logic [tcwu_pkg::WIN_W-1:0]    loss_raw;
   logic [tcwu_pkg::WIN_W-1:0]    loss_win;
   logic [tcwu_pkg::SUM_W-1:0]    slow_sum;
   logic [tcwu_pkg::WIN_W-1:0]    slow_win;
   logic [tcwu_pkg::SUM_W-1:0]    avoid_sum;
   logic [tcwu_pkg::WIN_W-1:0]    avoid_win;
   logic [tcwu_pkg::SUM_W-1:0]    trial;
   logic [tcwu_pkg::SUM_W-1:0]    diff;
   logic                          fits;

   assign ack_sum  = {2'b00, req_random_draw} + {1'b0, prob_ff};
   assign loss_raw = prod_ff[tcwu_pkg::PROD_W-1:tcwu_pkg::FRAC_W];
   assign loss_win = (loss_raw < tcwu_pkg::WIN_ONE) ? tcwu_pkg::WIN_ONE : loss_raw;

   assign slow_sum = {1'b0, win_ff} + tcwu_pkg::SUM_W'(step_ff);
   assign slow_win = (slow_sum > {1'b0, tcwu_pkg::WIN_MAX}) ? tcwu_pkg::WIN_MAX
                                                           : slow_sum[tcwu_pkg::WIN_W-1:0];
   assign avoid_sum = {1'b0, win_ff} + tcwu_pkg::SUM_W'(quo_ff);
   assign avoid_win = (avoid_sum > {1'b0, tcwu_pkg::WIN_MAX}) ? tcwu_pkg::WIN_MAX
                                                             : avoid_sum[tcwu_pkg::WIN_W-1:0];

   assign trial = {rem_ff, quo_ff[tcwu_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, win_ff};
   assign fits  = (trial >= {1'b0, win_ff});

   assign status.lost = lost_ff;
   assign status.slow = slow_ff;

   assign rsp_window        = out_win_ff;
   assign rsp_in_slow_start = out_slow_ff;
   assign rsp_loss_seen     = out_lost_ff;

   always_comb begin
      step_in        = step_ff;
      gain_in        = gain_ff;
      factor_in      = factor_ff;
      prob_in        = prob_ff;
      win_in         = win_ff;
      thr_in         = thr_ff;
      slow_in        = slow_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tcwu_pkg::CSR_INIT_WINDOW: begin
               win_in         = tcwu_pkg::clamp_window(csr_wdata);
               thr_in         = tcwu_pkg::WIN_INF;
               slow_in        = 1'b1;
            end
            tcwu_pkg::CSR_SLOW_START_STEP: step_in   = csr_wdata[tcwu_pkg::STEP_W-1:0];
            tcwu_pkg::CSR_AVOID_GAIN:      gain_in   = csr_wdata[tcwu_pkg::STEP_W-1:0];
            tcwu_pkg::CSR_LOSS_FACTOR:     factor_in = csr_wdata[tcwu_pkg::FACTOR_W-1:0];
            tcwu_pkg::CSR_SUCCESS_PROB:    prob_in   = csr_wdata[tcwu_pkg::PROB_W-1:0];
            default: begin
            end
         endcase
      end else if (cmd.update) begin
         if (lost_ff) begin
            thr_in  = {1'b0, win_ff[tcwu_pkg::WIN_W-1:1]};
            win_in  = loss_win;
            slow_in = 1'b1;
         end else if (slow_ff) begin
            win_in = slow_win;
            if (thr_ff <= slow_win) begin
               slow_in = 1'b0;
            end
         end else begin
            win_in = avoid_win;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= tcwu_pkg::RST_SLOW_START_STEP;
         gain_ff        <= tcwu_pkg::RST_AVOID_GAIN;
         factor_ff      <= tcwu_pkg::RST_LOSS_FACTOR;
         prob_ff        <= tcwu_pkg::RST_SUCCESS_PROB;
         win_ff         <= tcwu_pkg::clamp_window(tcwu_pkg::WIN_ONE);
         thr_ff         <= tcwu_pkg::WIN_INF;
         slow_ff        <= 1'b1;
      end else begin
         step_ff        <= step_in;
         gain_ff        <= gain_in;
         factor_ff      <= factor_in;
         prob_ff        <= prob_in;
         win_ff         <= win_in;
         thr_ff         <= thr_in;
         slow_ff        <= slow_in;
      end
   end

   // decrease product and loss decision, taken with the beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lost_ff <= (ack_sum < tcwu_pkg::PROB_ONE);
         prod_ff <= tcwu_pkg::PROD_W'(factor_ff) * tcwu_pkg::PROD_W'(win_ff);
      end
   end

   // restoring divider: (gain << 8) / window, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= {gain_ff, {tcwu_pkg::FRAC_W{1'b0}}};
      end else if (cmd.div_step) begin
         rem_ff <= fits ? diff[tcwu_pkg::WIN_W-1:0] : trial[tcwu_pkg::WIN_W-1:0];
         quo_ff <= {quo_ff[tcwu_pkg::QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_win_ff  <= win_ff;
         out_slow_ff <= slow_ff;
         out_lost_ff <= lost_ff;
      end
   end

endmodule

// ----- hdl/tcp_congestion_window_update.sv -----
// On a loss or in slow start a beat goes from evaluation to the window update and then
// to the result register; in congestion avoidance an 18-step restoring divider first
// computes gain / window one quotient bit per cycle. A new beat is taken once the
// previous one has moved into the result register, which can wait on rsp_stall.
// Synchronous reset restores register defaults, window 1.0 segment, infinite threshold,
// slow start, and an empty result register.
module tcp_congestion_window_update (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [tcwu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcwu_pkg::WIN_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tcwu_pkg::DRAW_W-1:0]     req_random_draw,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcwu_pkg::WIN_W-1:0]      rsp_window,
   output logic                            rsp_in_slow_start,
   output logic                            rsp_loss_seen
);

   tcwu_pkg::cmd_type    cmd;
   tcwu_pkg::status_type status;

   tcwu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcwu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_random_draw   (req_random_draw),
      .cmd               (cmd),
      .status            (status),
      .rsp_window        (rsp_window),
      .rsp_in_slow_start (rsp_in_slow_start),
      .rsp_loss_seen     (rsp_loss_seen)
   );

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after an accepted beat");

   a_window_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window != '0) && (rsp_window <= tcwu_pkg::WIN_MAX))
      else $error("result window out of range");

   a_loss_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_loss_seen |-> rsp_in_slow_start && (rsp_window >= tcwu_pkg::WIN_ONE))
      else $error("loss result without slow start or below one segment");

endmodule
